// ----- hw/rtl/ads_pkg.sv -----
// ----------------------------------------------------------------------------
// ads_pkg
// Shared widths, codes and the per-slot record of the activity statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ads_pkg;

    localparam int NUM_ACTIVITIES_DEF = 16;

    localparam int ACT_W   = 4;
    localparam int TS_W    = 64;
    localparam int DUR_W   = 32;
    localparam int MEAN_W  = 40;
    localparam int CNT_W   = 31;
    localparam int ST_W    = 2;
    localparam int NUMER_W = 72;
    localparam int FRAC_W  = 8;

    localparam logic [CNT_W-1:0] TALLY_MAX = '1;
    localparam logic [DUR_W-1:0] DUR_MAX   = '1;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef struct packed {
        logic [TS_W-1:0]   stamp;
        logic [CNT_W-1:0]  stally;
        logic [CNT_W-1:0]  etally;
        logic [DUR_W-1:0]  shortest;
        logic [DUR_W-1:0]  longest;
        logic [MEAN_W-1:0] mean;
    } t_row;

    localparam t_row ROW_RESET = '{
        stamp:    '0,
        stally:   '0,
        etally:   '0,
        shortest: '1,
        longest:  '0,
        mean:     '0
    };

endpackage

`default_nettype wire

// ----- hw/rtl/ads_mean_div.sv -----
// ----------------------------------------------------------------------------
// ads_mean_div
// Bit-serial running mean: shift-add multiply of mean by (n-1), plus d<<8,
// then restoring division by n, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ads_mean_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ads_pkg::MEAN_W-1:0]  i_mean,
    input  wire logic [ads_pkg::DUR_W-1:0]   i_dur,
    input  wire logic [ads_pkg::CNT_W-1:0]   i_n,
    output logic                             o_done,
    output logic [ads_pkg::MEAN_W-1:0]       o_mean
);
    import ads_pkg::*;

    localparam int CW = $clog2(NUMER_W + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;

    logic [1:0]         r_phase, n_phase;
    logic               r_done, n_done;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [NUMER_W-1:0] r_acc, n_acc;
    logic [NUMER_W-1:0] r_mcand, n_mcand;
    logic [CNT_W-1:0]   r_mplier, n_mplier;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_div, n_div;
    logic [CNT_W:0]     trial;
    logic               qbit;

    always_comb begin
        n_phase  = r_phase;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_rem    = r_rem;
        n_div    = r_div;
        trial    = {r_rem, r_acc[NUMER_W-1]};
        qbit     = (trial >= {1'b0, r_div});
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_acc    = NUMER_W'({i_dur, {FRAC_W{1'b0}}});
                    n_mcand  = NUMER_W'(i_mean);
                    n_mplier = i_n - CNT_W'(1);
                    n_div    = i_n;
                    n_cnt    = CW'(CNT_W);
                    n_phase  = P_MUL;
                end
            end
            P_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[NUMER_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[CNT_W-1:1]};
                n_cnt    = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_cnt   = CW'(NUMER_W);
                    n_rem   = '0;
                    n_phase = P_DIV;
                end
            end
            P_DIV: begin
                if (qbit) begin
                    n_rem = CNT_W'(trial - {1'b0, r_div});
                end else begin
                    n_rem = trial[CNT_W-1:0];
                end
                n_acc = {r_acc[NUMER_W-2:0], qbit};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_rem    <= n_rem;
        r_div    <= n_div;
    end

    assign o_done = r_done;
    assign o_mean = r_acc[MEAN_W-1:0];

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_DIV) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_phase == P_IDLE))
        else $error("start while busy");

    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_phase == P_DIV))
        else $error("done without division");

endmodule

`default_nettype wire

// ----- hw/rtl/activity_duration_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// activity_duration_statistics_unit
// Start event, bad slot, overflow or unbalanced end: evaluate in S_EVAL, then write back in S_WB.
// Balanced end: evaluate, then serial multiply and serial divide in S_MEAN, then S_WB.
// One item at a time; the next transfer is taken once the result is registered and the
// unit is back in S_IDLE; a result held by the receiver stalls the next item in S_WB.
// Synchronous active-low reset: all slots read as empty, min all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module activity_duration_statistics_unit #(
    parameter int NUM_ACTIVITIES = ads_pkg::NUM_ACTIVITIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_opcode,
    input  wire logic [ads_pkg::ACT_W-1:0]   i_activity,
    input  wire logic [ads_pkg::TS_W-1:0]    i_timestamp_us,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [ads_pkg::ST_W-1:0]         o_status,
    output logic [ads_pkg::DUR_W-1:0]        o_duration_us,
    output logic [ads_pkg::DUR_W-1:0]        o_min_us,
    output logic [ads_pkg::DUR_W-1:0]        o_max_us,
    output logic [ads_pkg::MEAN_W-1:0]       o_mean_us_q8,
    output logic [ads_pkg::CNT_W-1:0]        o_completed
);
    import ads_pkg::*;

    localparam int AW = (NUM_ACTIVITIES > 1) ? $clog2(NUM_ACTIVITIES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_MEAN = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    t_row                r_mem [NUM_ACTIVITIES];
    logic [NUM_ACTIVITIES-1:0] r_vld;

    logic [1:0]          r_state;
    logic                r_out_valid;
    logic                r_op;
    logic                r_bad;
    logic [AW-1:0]       r_idx;
    logic [TS_W-1:0]     r_ts;
    t_row                r_rd_row;
    logic                r_rd_vld;
    t_row                r_row;
    logic [ST_W-1:0]     r_status;
    logic [DUR_W-1:0]    r_dur;
    logic                r_wr;

    logic                in_fire;
    logic                wb_fire;
    logic [AW-1:0]       in_idx;
    t_row                row;
    logic [TS_W:0]       diff;
    logic [DUR_W-1:0]    dur;
    t_row                e_row;
    logic [ST_W-1:0]     e_status;
    logic [DUR_W-1:0]    e_dur;
    logic                e_mean;
    logic                u_start;
    logic                u_done;
    logic [MEAN_W-1:0]   u_mean;

    assign o_ready = (r_state == S_IDLE);
    assign in_fire = i_valid && o_ready;
    assign in_idx  = AW'(i_activity);
    assign wb_fire = (r_state == S_WB) && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;

    always_comb begin
        row  = r_rd_vld ? r_rd_row : ROW_RESET;
        diff = {1'b0, r_ts} - {1'b0, row.stamp};
        if (diff[TS_W]) begin
            dur = '0;
        end else if (|diff[TS_W-1:DUR_W]) begin
            dur = DUR_MAX;
        end else begin
            dur = diff[DUR_W-1:0];
        end

        e_row    = row;
        e_status = ST_OK;
        e_dur    = '0;
        e_mean   = 1'b0;
        if (r_bad) begin
            e_row    = '0;
            e_status = ST_BAD;
        end else if (r_op == OP_START) begin
            e_row.stamp = r_ts;
            if (row.stally == TALLY_MAX) begin
                e_status = ST_OVF;
            end else begin
                e_row.stally = row.stally + CNT_W'(1);
            end
        end else begin
            if (row.etally == TALLY_MAX) begin
                e_status = ST_OVF;
            end else begin
                e_row.etally = row.etally + CNT_W'(1);
                if (row.stally != e_row.etally) begin
                    e_status = ST_BAD;
                end else begin
                    e_dur  = dur;
                    e_mean = 1'b1;
                    if (dur < row.shortest) begin
                        e_row.shortest = dur;
                    end
                    if (dur > row.longest) begin
                        e_row.longest = dur;
                    end
                end
            end
        end
    end

    assign u_start = (r_state == S_EVAL) && e_mean;

    ads_mean_div u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u_start),
        .i_mean  (row.mean),
        .i_dur   (e_dur),
        .i_n     (e_row.etally),
        .o_done  (u_done),
        .o_mean  (u_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= e_mean ? S_MEAN : S_WB;
                end
                S_MEAN: begin
                    if (u_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (wb_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (wb_fire && r_wr) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= i_opcode;
            r_ts     <= i_timestamp_us;
            r_idx    <= in_idx;
            r_bad    <= ({{(32-ACT_W){1'b0}}, i_activity} >= 32'(NUM_ACTIVITIES));
            r_rd_row <= r_mem[in_idx];
            r_rd_vld <= r_vld[in_idx];
        end
        if (r_state == S_EVAL) begin
            r_row    <= e_row;
            r_status <= e_status;
            r_dur    <= e_dur;
            r_wr     <= !r_bad;
        end
        if ((r_state == S_MEAN) && u_done) begin
            r_row.mean <= u_mean;
        end
        if (wb_fire) begin
            if (r_wr) begin
                r_mem[r_idx] <= r_row;
            end
            o_status      <= r_status;
            o_duration_us <= r_dur;
            o_min_us      <= r_row.shortest;
            o_max_us      <= r_row.longest;
            o_mean_us_q8  <= r_row.mean;
            o_completed   <= r_row.etally;
        end
    end

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EVAL))
        else $error("transfer not followed by evaluation");

    a_done_in_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> (r_state == S_MEAN))
        else $error("mean result outside mean wait");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_WB))
        else $error("result posted outside write-back");

endmodule

`default_nettype wire
